// ===== sv/salru_pkg.sv =====
`default_nettype none

package salru_pkg;

  // Build-time defaults for the top-level parameters.
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_WAYS         = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  // Fixed field and register widths.
  localparam int ADDR_W          = 64;
  localparam int TAG_W           = 62;
  localparam int CNT_W           = 32;
  localparam int SET_BITS_W      = 3;
  localparam int BLOCK_BITS_W    = 6;
  localparam int WAYS_IN_USE_W   = 4;
  localparam int WAY_COUNT_W     = 5;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 6;
  localparam int SUM_W           = 7;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_FETCH  = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_BLOCK_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  address;
  } access_t;

  typedef struct packed {
    logic              first_hit;
    logic              miss;
    logic              evicted;
    logic              second_hit;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  evict_total;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/salru_ram.sv =====
`default_nettype none

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/set_associative_lru_cache_model_unit.sv =====
`default_nettype none

// Set-associative cache model with least-recently-used replacement. Each
// transfer on the command port (start while busy is low) carries one access:
// load, store, modify or instruction fetch, plus its byte address. Exactly one
// result comes back per access: done is high for a single cycle, set from the
// lookup stage valid, and the result register is loaded at the same edge.
// The receiver cannot stall it, so it must take every result as it
// appears. A new access may be started in
// every cycle and busy is never raised: the set lookup, replacement choice and
// LRU update for one access all finish in the cycle after the set row is read
// from the tag RAM, and a back-to-back access to the same set is served from a
// write-back bypass register. There is no clearing pass after reset: each set
// row carries a flip-flop valid bit, and a row never written reads as empty.
// The configuration registers (set bits, block bits, ways in use) are written
// through the cfg port, which is always ready; write them only while no access
// is in flight.
module set_associative_lru_cache_model_unit #(
  parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
  parameter int WAYS         = salru_pkg::DEF_WAYS,
  parameter int ADDR_WIDTH   = salru_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire salru_pkg::access_t               access,
  output logic                                  done,
  output salru_pkg::result_t                    result,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [salru_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import salru_pkg::*;

  localparam int SET_W     = MAX_SET_BITS;
  localparam int NSETS     = 1 << MAX_SET_BITS;
  localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W   = 1 + RANK_W + TAG_W;
  localparam int ROW_W     = WAYS * ENTRY_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_WIDTH);

  // Configuration registers.
  logic [SET_BITS_W-1:0]    index_bits;
  logic [BLOCK_BITS_W-1:0]  offset_bits;
  logic [WAYS_IN_USE_W-1:0] ways_in_use;

  // The configuration port never stalls. Writes to an index beyond the
  // register list are accepted and dropped.
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= SET_BITS_W'(1);
      offset_bits <= BLOCK_BITS_W'(1);
      ways_in_use <= WAYS_IN_USE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_BITS:    index_bits  <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS:  offset_bits <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use <= cfg_data[WAYS_IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective configuration: out-of-range settings are clamped into range.
  logic [3:0]              s_eff;
  logic [BLOCK_BITS_W-1:0] b_eff;
  logic [WAY_COUNT_W-1:0]  e_eff;

  always_comb begin
    if (index_bits == '0) begin
      s_eff = 4'd1;
    end else if ({1'b0, index_bits} > 4'(MAX_SET_BITS)) begin
      s_eff = 4'(MAX_SET_BITS);
    end else begin
      s_eff = {1'b0, index_bits};
    end
    b_eff = (offset_bits == '0) ? BLOCK_BITS_W'(1) : offset_bits;
    if (ways_in_use == '0) begin
      e_eff = WAY_COUNT_W'(1);
    end else if ({1'b0, ways_in_use} > WAY_COUNT_W'(WAYS)) begin
      e_eff = WAY_COUNT_W'(WAYS);
    end else begin
      e_eff = {1'b0, ways_in_use};
    end
  end

  // Address split at the start edge. The set index also addresses the RAM
  // read so the row is ready when the access reaches the lookup stage.
  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] addr_sh_b;
  logic [ADDR_W-1:0] addr_sh_t;
  logic [SUM_W-1:0]  sb_sum;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;

  always_comb begin
    addr_m    = access.address & ADDR_MASK;
    addr_sh_b = addr_m >> b_eff;
    set_mask  = ~({SET_W{1'b1}} << s_eff);
    in_set    = addr_sh_b[SET_W-1:0] & set_mask;
    sb_sum    = SUM_W'(s_eff) + SUM_W'(b_eff);
    addr_sh_t = addr_m >> sb_sum;
    in_tag    = (sb_sum >= SUM_W'(ADDR_W)) ? '0 : addr_sh_t[TAG_W-1:0];
  end

  // Lookup stage registers.
  logic             s1_valid;
  mode_t            s1_mode;
  logic [SET_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_mode <= access.mode;
      s1_set  <= in_set;
      s1_tag  <= in_tag;
    end
  end

  // Set rows: each way holds {valid, rank, tag}.
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_next;
  logic             wr_en;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_set),
    .wdata (row_next),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // A row whose valid bit is clear has never been written and reads as an
  // empty set. The bypass register holds the row written at the last edge,
  // which the RAM read taken at that same edge did not yet see.
  logic [NSETS-1:0] row_valid;
  logic             fwd_valid;
  logic [SET_W-1:0] fwd_set;
  logic [ROW_W-1:0] fwd_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      if (wr_en) begin
        row_valid[s1_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_set <= s1_set;
      fwd_row <= row_next;
    end
  end

  // Lookup, replacement choice and LRU rank update.
  logic [ROW_W-1:0]     row_cur;
  logic [WAYS-1:0]      vld;
  logic [RANK_W-1:0]    rk     [WAYS];
  logic [TAG_W-1:0]     tg     [WAYS];
  logic [WAYS-1:0]      in_use;
  logic [WAYS-1:0]      hit_vec;
  logic [WAYS-1:0]      free_vec;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] free_way;
  logic [WAY_IDX_W-1:0] victim;
  logic [WAY_IDX_W-1:0] target;
  logic                 hit_flag;
  logic                 miss_flag;
  logic                 evict_flag;
  logic                 modify_flag;
  logic                 was_valid;
  logic [RANK_W-1:0]    old_rank;
  logic [WAYS-1:0]      vld_next;
  logic [RANK_W-1:0]    rk_next [WAYS];
  logic [TAG_W-1:0]     tg_next [WAYS];

  always_comb begin
    if (fwd_valid && (fwd_set == s1_set)) begin
      row_cur = fwd_row;
    end else if (row_valid[s1_set]) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end

    for (int w = 0; w < WAYS; w++) begin
      vld[w]      = row_cur[w*ENTRY_W + RANK_W + TAG_W];
      rk[w]       = row_cur[w*ENTRY_W + TAG_W +: RANK_W];
      tg[w]       = row_cur[w*ENTRY_W +: TAG_W];
      in_use[w]   = WAY_COUNT_W'(w) < e_eff;
      hit_vec[w]  = in_use[w] && vld[w] && (tg[w] == s1_tag);
      free_vec[w] = in_use[w] && !vld[w];
    end

    // Lowest-numbered matching and free ways.
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_IDX_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_IDX_W'(w);
      end
    end

    // Oldest way in use; the lowest-numbered one wins a tie.
    victim = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (rk[w] > rk[victim])) begin
        victim = WAY_IDX_W'(w);
      end
    end

    modify_flag = (s1_mode == MODE_MODIFY);
    wr_en       = s1_valid && (s1_mode != MODE_FETCH);
    hit_flag    = wr_en && (hit_vec != '0);
    miss_flag   = wr_en && (hit_vec == '0);
    evict_flag  = miss_flag && (free_vec == '0);

    if (hit_vec != '0) begin
      target = hit_way;
    end else if (free_vec != '0) begin
      target = free_way;
    end else begin
      target = victim;
    end

    // The touched way becomes the newest. Every other valid way ages when
    // an empty way is filled, otherwise only those newer than the touched one.
    was_valid = vld[target];
    old_rank  = rk[target];
    for (int w = 0; w < WAYS; w++) begin
      vld_next[w] = vld[w];
      rk_next[w]  = rk[w];
      tg_next[w]  = tg[w];
      if (WAY_IDX_W'(w) == target) begin
        vld_next[w] = 1'b1;
        rk_next[w]  = '0;
        tg_next[w]  = s1_tag;
      end else if (vld[w] && (!was_valid || (rk[w] < old_rank))) begin
        rk_next[w] = rk[w] + RANK_W'(1);
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      row_next[w*ENTRY_W +: ENTRY_W] = {vld_next[w], rk_next[w], tg_next[w]};
    end
  end

  // Running totals; they wrap at 32 bits.
  logic [CNT_W-1:0] hit_counter;
  logic [CNT_W-1:0] miss_counter;
  logic [CNT_W-1:0] evict_counter;
  logic [CNT_W-1:0] hit_counter_next;
  logic [CNT_W-1:0] miss_counter_next;
  logic [CNT_W-1:0] evict_counter_next;

  always_comb begin
    hit_counter_next   = hit_counter + CNT_W'(hit_flag)
                         + CNT_W'(s1_valid && modify_flag);
    miss_counter_next  = miss_counter + CNT_W'(miss_flag);
    evict_counter_next = evict_counter + CNT_W'(evict_flag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter   <= '0;
      miss_counter  <= '0;
      evict_counter <= '0;
      done          <= 1'b0;
    end else begin
      done <= s1_valid;
      if (s1_valid) begin
        hit_counter   <= hit_counter_next;
        miss_counter  <= miss_counter_next;
        evict_counter <= evict_counter_next;
      end
    end
  end

  // Result register: one transfer per access, held until the next access.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.first_hit   <= hit_flag;
      result.miss        <= miss_flag;
      result.evicted     <= evict_flag;
      result.second_hit  <= modify_flag;
      result.hit_total   <= hit_counter_next;
      result.miss_total  <= miss_counter_next;
      result.evict_total <= evict_counter_next;
    end
  end

endmodule

`default_nettype wire
